// ===== rtl/core/toolpath_fixed_step_resampler_assert.svh =====
// ----------------------------------------------------------------------------
// Toolpath resampler assertion macros
// Clocked assertion shorthands used by the resampler RTL.
// ----------------------------------------------------------------------------
`ifndef TOOLPATH_FIXED_STEP_RESAMPLER_ASSERT_SVH
`define TOOLPATH_FIXED_STEP_RESAMPLER_ASSERT_SVH

// A property checked at every rising clock edge outside reset.
`define TFSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// An implication checked in the same cycle outside reset.
`define TFSR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tfsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Toolpath resampler package
// Request types, widths and constants shared by the resampler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tfsr_pkg;

    localparam int MAX_POINTS = 32;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DELTA_W = 34;
    localparam logic [31:0] STEP_RESET = 32'd65536;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [31:0] seg_length;
        logic [31:0] feed_rate;
        logic [31:0] bed_temp;
        logic [31:0] tool_power;
        logic chunk_first;
        logic chunk_last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] out_dir_x;
        logic signed [15:0] out_dir_y;
        logic signed [15:0] out_dir_z;
        logic [31:0] out_length;
        logic [31:0] out_feed;
        logic [31:0] out_bed;
        logic [31:0] out_power;
        logic starts_chunk;
        logic run_last;
    } out_item_t;

    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
    } unit_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tfsr_count_unit.sv =====
// ----------------------------------------------------------------------------
// Toolpath resampler point counter
// Restoring division of segment length by step, one quotient bit per cycle,
// capped at the maximum number of points.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsr_count_unit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire tfsr_pkg::unit_ctrl_t    ctrl,
    output tfsr_pkg::unit_stat_t         stat,
    input  wire logic [31:0]             seg_len,
    input  wire logic [31:0]             step,
    output logic [tfsr_pkg::CNT_W-1:0]   count
);
    import tfsr_pkg::*;

    localparam int DW = 32 + CNT_W;
    localparam int KW = $clog2(CNT_W + 1);

    logic busy_reg;
    logic [KW-1:0] k_reg;
    logic [DW-1:0] rem_reg;
    logic [CNT_W-1:0] q_reg;
    logic [CNT_W-1:0] count_reg;

    logic [DW-1:0] shifted;
    logic geq;
    logic [DW-1:0] diff;
    logic [CNT_W-1:0] q_fin;

    always_comb
    begin
        shifted = {{CNT_W{1'b0}}, step} << k_reg;
        geq = rem_reg >= shifted;
        diff = rem_reg - shifted;
        q_fin = (q_reg << 1) | CNT_W'(geq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg <= '0;
            rem_reg <= '0;
            q_reg <= '0;
            count_reg <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            k_reg <= KW'(CNT_W);
            rem_reg <= {{CNT_W{1'b0}}, seg_len};
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (k_reg == KW'(CNT_W))
            begin
                if (geq)
                begin
                    count_reg <= CNT_W'(MAX_POINTS);
                    busy_reg <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
            else
            begin
                if (geq)
                begin
                    rem_reg <= diff;
                end
                q_reg <= q_fin;
                if (k_reg == '0)
                begin
                    count_reg <= (q_fin > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : q_fin;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tfsr_delta_unit.sv =====
// ----------------------------------------------------------------------------
// Toolpath resampler step delta unit
// One shared multiplier scales the step by each direction component in turn
// and rounds the product half toward plus infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsr_delta_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tfsr_pkg::unit_ctrl_t                ctrl,
    output tfsr_pkg::unit_stat_t                     stat,
    input  wire logic [31:0]                         step,
    input  wire logic [2:0][15:0]                    dir,
    output logic [2:0][tfsr_pkg::DELTA_W-1:0]        delta
);
    import tfsr_pkg::*;

    localparam logic [1:0] IDX_LAST = 2'd3;

    logic busy_reg;
    logic [1:0] idx_reg;
    logic signed [48:0] prod_reg;
    logic [2:0][DELTA_W-1:0] delta_reg;

    logic signed [15:0] sel_dir;
    logic signed [48:0] rounded;

    always_comb
    begin
        unique case (idx_reg)
            2'd0: sel_dir = $signed(dir[0]);
            2'd1: sel_dir = $signed(dir[1]);
            2'd2: sel_dir = $signed(dir[2]);
            default: sel_dir = '0;
        endcase
        rounded = prod_reg + 49'sd16384;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
            prod_reg <= '0;
            delta_reg <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (idx_reg != IDX_LAST)
            begin
                prod_reg <= $signed({1'b0, step}) * sel_dir;
            end
            unique case (idx_reg)
                2'd1: delta_reg[0] <= rounded[48:15];
                2'd2: delta_reg[1] <= rounded[48:15];
                2'd3: delta_reg[2] <= rounded[48:15];
                default: ;
            endcase
            if (idx_reg == IDX_LAST)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign delta = delta_reg;

endmodule

`default_nettype wire

// ===== rtl/core/toolpath_fixed_step_resampler.sv =====
// A request accepted while a point is held starts its flush in S_SETUP, before its own point is handled.
// A run first sets up (count division and three multiplies) in S_SETUP and S_WAIT, then emits its points.
// Results leave through one output register, one per cycle within a run while not stalled.
// Reset (rst_n, asynchronous, active low) clears the held point and sets step to 1.0 mm.
// ----------------------------------------------------------------------------
// Fixed-step toolpath resampler
// Sequencer that expands toolpath points into runs spaced by a fixed step, passes some points through and drops others.
// ----------------------------------------------------------------------------
`default_nettype none

`include "toolpath_fixed_step_resampler_assert.svh"

module toolpath_fixed_step_resampler (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire tfsr_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output tfsr_pkg::out_item_t       out_data,
    input  wire logic                 step_wr_en,
    input  wire logic [31:0]          step_wr_data
);
    import tfsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_SETUP,
        S_WAIT,
        S_ADV,
        S_EMIT,
        S_PASS
    } state_t;

    typedef enum logic [1:0] {
        K_SKIP,
        K_PASS,
        K_HOLD,
        K_RUN
    } kind_t;

    state_t state_reg;
    kind_t kind_reg;
    kind_t kind_next;
    in_item_t item_reg;
    logic [31:0] step_reg;
    logic held_valid_reg;
    logic [2:0][31:0] held_pos_reg;
    logic [2:0][15:0] held_dir_reg;
    logic [31:0] held_len_reg;
    logic [2:0][31:0] pos_reg;
    logic [2:0][15:0] run_dir_reg;
    logic [31:0] run_len_reg;
    logic run_origin_reg;
    logic run_opens_reg;
    logic run_final_reg;
    logic held_phase_reg;
    logic [CNT_W-1:0] i_reg;
    logic out_valid_reg;
    out_item_t out_data_reg;

    unit_ctrl_t unit_ctrl;
    unit_stat_t cnt_stat;
    unit_stat_t dlt_stat;
    logic [CNT_W-1:0] cnt_n;
    logic [2:0][DELTA_W-1:0] delta;
    logic [2:0][31:0] adv_pos;
    logic slot_free;
    logic out_load;
    logic in_accept;
    logic is_long;
    logic last_point;

    function automatic logic [31:0] sat_add(input logic signed [31:0] a,
                                            input logic signed [DELTA_W-1:0] d);
        logic signed [DELTA_W:0] sum;
        logic [31:0] res;
        sum = {{(DELTA_W - 31){a[31]}}, a} + {d[DELTA_W-1], d};
        if (sum[DELTA_W:31] == '0 || sum[DELTA_W:31] == '1)
        begin
            res = sum[31:0];
        end
        else if (sum[DELTA_W])
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    tfsr_count_unit u_count (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (unit_ctrl),
        .stat    (cnt_stat),
        .seg_len (run_len_reg),
        .step    (step_reg),
        .count   (cnt_n)
    );

    tfsr_delta_unit u_delta (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (unit_ctrl),
        .stat  (dlt_stat),
        .step  (step_reg),
        .dir   (run_dir_reg),
        .delta (delta)
    );

    always_comb
    begin
        unit_ctrl.start = (state_reg == S_SETUP);
        in_stall = (state_reg != S_IDLE);
        in_accept = in_valid && !in_stall;
        slot_free = !out_valid_reg || !out_stall;
        out_load = slot_free && (state_reg == S_EMIT || state_reg == S_PASS);
        is_long = in_data.seg_length >= step_reg;
        last_point = ((i_reg + 1'b1) == cnt_n);
        for (int j = 0; j < 3; j++)
        begin
            adv_pos[j] = sat_add(pos_reg[j], delta[j]);
        end
        priority if (in_data.chunk_first && in_data.chunk_last)
        begin
            kind_next = K_SKIP;
        end
        else if (in_data.chunk_last)
        begin
            kind_next = K_PASS;
        end
        else if (in_data.chunk_first)
        begin
            kind_next = is_long ? K_HOLD : K_PASS;
        end
        else
        begin
            kind_next = is_long ? K_RUN : K_SKIP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg <= K_SKIP;
            item_reg <= '0;
            step_reg <= STEP_RESET;
            held_valid_reg <= 1'b0;
            held_pos_reg <= '0;
            held_dir_reg <= '0;
            held_len_reg <= '0;
            pos_reg <= '0;
            run_dir_reg <= '0;
            run_len_reg <= '0;
            run_origin_reg <= 1'b0;
            run_opens_reg <= 1'b0;
            run_final_reg <= 1'b0;
            held_phase_reg <= 1'b0;
            i_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (step_wr_en)
            begin
                step_reg <= step_wr_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        item_reg <= in_data;
                        kind_reg <= kind_next;
                        if (held_valid_reg)
                        begin
                            held_valid_reg <= 1'b0;
                            held_phase_reg <= 1'b1;
                            pos_reg <= held_pos_reg;
                            run_dir_reg <= held_dir_reg;
                            run_len_reg <= held_len_reg;
                            run_origin_reg <= 1'b1;
                            run_opens_reg <= 1'b1;
                            run_final_reg <= !(kind_next == K_PASS || kind_next == K_RUN);
                            state_reg <= S_SETUP;
                        end
                        else
                        begin
                            state_reg <= S_NEXT;
                        end
                    end
                end
                S_NEXT:
                begin
                    unique case (kind_reg)
                        K_SKIP: state_reg <= S_IDLE;
                        K_PASS: state_reg <= S_PASS;
                        K_HOLD:
                        begin
                            held_valid_reg <= 1'b1;
                            held_pos_reg <= {item_reg.pos_z, item_reg.pos_y, item_reg.pos_x};
                            held_dir_reg <= {item_reg.dir_z, item_reg.dir_y, item_reg.dir_x};
                            held_len_reg <= item_reg.seg_length;
                            state_reg <= S_IDLE;
                        end
                        K_RUN:
                        begin
                            pos_reg <= {item_reg.pos_z, item_reg.pos_y, item_reg.pos_x};
                            run_dir_reg <= {item_reg.dir_z, item_reg.dir_y, item_reg.dir_x};
                            run_len_reg <= item_reg.seg_length;
                            run_origin_reg <= 1'b0;
                            run_opens_reg <= 1'b0;
                            run_final_reg <= 1'b1;
                            state_reg <= S_SETUP;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_SETUP:
                begin
                    i_reg <= '0;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!cnt_stat.busy && !dlt_stat.busy)
                    begin
                        if (cnt_n == '0)
                        begin
                            held_phase_reg <= 1'b0;
                            state_reg <= held_phase_reg ? S_NEXT : S_IDLE;
                        end
                        else if (run_origin_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_ADV;
                        end
                    end
                end
                S_ADV:
                begin
                    pos_reg <= adv_pos;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_data_reg.out_x <= pos_reg[0];
                        out_data_reg.out_y <= pos_reg[1];
                        out_data_reg.out_z <= pos_reg[2];
                        out_data_reg.out_dir_x <= run_dir_reg[0];
                        out_data_reg.out_dir_y <= run_dir_reg[1];
                        out_data_reg.out_dir_z <= run_dir_reg[2];
                        out_data_reg.out_length <= step_reg;
                        out_data_reg.out_feed <= item_reg.feed_rate;
                        out_data_reg.out_bed <= item_reg.bed_temp;
                        out_data_reg.out_power <= item_reg.tool_power;
                        out_data_reg.starts_chunk <= run_opens_reg && (i_reg == '0);
                        out_data_reg.run_last <= run_final_reg && last_point;
                        pos_reg <= adv_pos;
                        i_reg <= i_reg + 1'b1;
                        if (last_point)
                        begin
                            held_phase_reg <= 1'b0;
                            state_reg <= held_phase_reg ? S_NEXT : S_IDLE;
                        end
                    end
                end
                S_PASS:
                begin
                    if (slot_free)
                    begin
                        out_data_reg.out_x <= item_reg.pos_x;
                        out_data_reg.out_y <= item_reg.pos_y;
                        out_data_reg.out_z <= item_reg.pos_z;
                        out_data_reg.out_dir_x <= item_reg.dir_x;
                        out_data_reg.out_dir_y <= item_reg.dir_y;
                        out_data_reg.out_dir_z <= item_reg.dir_z;
                        out_data_reg.out_length <= item_reg.seg_length;
                        out_data_reg.out_feed <= item_reg.feed_rate;
                        out_data_reg.out_bed <= item_reg.bed_temp;
                        out_data_reg.out_power <= item_reg.tool_power;
                        out_data_reg.starts_chunk <= item_reg.chunk_first;
                        out_data_reg.run_last <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    `TFSR_ASSERT(a_units_idle, (state_reg == S_IDLE) |-> (!cnt_stat.busy && !dlt_stat.busy),
                 "arithmetic unit busy while idle")
    `TFSR_ASSERT(a_emit_index, (state_reg == S_EMIT) |-> (i_reg < cnt_n),
                 "point index past run count")
    `TFSR_ASSERT(a_count_cap, (!cnt_stat.busy) |-> (cnt_n <= CNT_W'(MAX_POINTS)),
                 "point count above cap")
    `TFSR_ASSERT_IMPL(a_no_hold_in_flush, held_phase_reg, !held_valid_reg,
                      "point held during flush")

endmodule

`default_nettype wire
